@@ design/jsu_pkg.sv @@
// shared types and constants for the json string unescape block
`default_nettype none

package jsu_pkg;

  localparam int MAX_RESULTS = 6;

  // decoder modes
  typedef enum logic [2:0] {
    MODE_PLAIN   = 3'd0,
    MODE_ESC     = 3'd1,
    MODE_HEX1    = 3'd2,
    MODE_WAIT_BS = 3'd3,
    MODE_WAIT_U  = 3'd4,
    MODE_HEX2    = 3'd5
  } jsu_mode_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_DATA    = 3'd0,
    ST_DONE    = 3'd1,
    ST_CTRL    = 3'd2,
    ST_BAD_ESC = 3'd3,
    ST_BAD_HEX = 3'd4,
    ST_UNTERM  = 3'd5
  } jsu_status_t;

  // all results caused by one input item; status applies to the final entry
  typedef struct packed {
    logic [2:0]                    cnt;
    jsu_status_t                   status;
    logic [MAX_RESULTS-1:0][7:0]   bytes;
  } jsu_burst_t;

  typedef struct packed {
    logic [2:0]       n;
    logic [3:0][7:0]  bytes;
  } jsu_utf8_t;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CTRL_LIMIT = 8'h20;

  localparam logic [7:0] REPL_B0 = 8'hEF;
  localparam logic [7:0] REPL_B1 = 8'hBF;
  localparam logic [7:0] REPL_B2 = 8'hBD;

endpackage

`default_nettype wire

@@ design/json_string_unescape_utf8_core.sv @@
// top level of the json string unescaper: decoder, burst queue and output serializer
`default_nettype none

// Takes the bytes after the opening quote of a JSON string, one byte per input
// item (in_tuser[0] set marks end of input with no byte), and returns the decoded
// UTF-8 bytes, then one terminating item whose out_tuser status says how the
// string ended; out_tlast flags the last result of each input item. The decoder
// takes one input item every cycle as long as the burst queue (QUEUE_DEPTH
// entries) has room; each item that causes results pushes one burst of 1 to 6
// results, and the serializer drives one result item per cycle whenever
// out_tready allows it. Each result is written into the burst queue and then
// registered in the serializer before it is presented. After a terminating
// result the decoder is back at the start of a new string.
module json_string_unescape_utf8_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // [7:0] data_byte
  input  wire  [0:0]  in_tuser,   // [0] end_mark
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic [2:0]  out_tuser,  // [2:0] status
  output logic        out_tlast   // last_of_run
);

  logic                push, q_full, q_valid, q_pop;
  jsu_pkg::jsu_burst_t burst, q_head;

  jsu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .push      (push),
    .burst     (burst)
  );

  jsu_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (burst),
    .full    (q_full),
    .pop     (q_pop),
    .q_valid (q_valid),
    .q_head  (q_head)
  );

  jsu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

@@ design/jsu_front.sv @@
// front end: escape and surrogate decoding, one item per cycle while the queue has room, emits result bursts
`default_nettype none

module jsu_front (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_tvalid,
  output logic                 in_tready,
  input  wire  [7:0]           in_tdata,   // [7:0] data_byte
  input  wire  [0:0]           in_tuser,   // [0] end_mark
  input  wire                  q_full,
  output logic                 push,
  output jsu_pkg::jsu_burst_t  burst
);

  jsu_pkg::jsu_mode_t mode_r, mode_nxt;
  logic [1:0]  hcnt_r, hcnt_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [9:0]  off_r, off_nxt;

  logic        fire;
  logic [7:0]  b;
  logic        endm;
  logic [3:0]  hexv;
  logic        hex_ok;
  logic [15:0] unit;
  logic        unit_hi, unit_lo;
  logic [20:0] pair_cp, cp_sel;
  logic        esc_ok;
  logic [7:0]  esc_val;
  jsu_pkg::jsu_utf8_t   enc, pay, plain_pay, esc_pay;
  jsu_pkg::jsu_status_t term, plain_term, esc_term;
  logic        rep;

  function automatic jsu_pkg::jsu_utf8_t utf8_enc(input logic [20:0] cp);
    jsu_pkg::jsu_utf8_t r;
    r.n     = 3'd0;
    r.bytes = '0;
    if (cp < 21'h80) begin
      r.n        = 3'd1;
      r.bytes[0] = cp[7:0];
    end else if (cp < 21'h800) begin
      r.n        = 3'd2;
      r.bytes[0] = {3'b110, cp[10:6]};
      r.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp < 21'h10000) begin
      r.n        = 3'd3;
      r.bytes[0] = {4'b1110, cp[15:12]};
      r.bytes[1] = {2'b10, cp[11:6]};
      r.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      r.n        = 3'd4;
      r.bytes[0] = {5'b11110, cp[20:18]};
      r.bytes[1] = {2'b10, cp[17:12]};
      r.bytes[2] = {2'b10, cp[11:6]};
      r.bytes[3] = {2'b10, cp[5:0]};
    end
    return r;
  endfunction

  assign in_tready = !q_full;
  assign fire      = in_tvalid && !q_full;
  assign b         = in_tdata;
  assign endm      = in_tuser[0];

  always_comb begin
    hex_ok = 1'b1;
    hexv   = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      hexv = b[3:0];
    end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
      hexv = b[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign unit    = {acc_r[11:0], hexv};
  assign unit_hi = (unit[15:10] == 6'b110110);
  assign unit_lo = (unit[15:10] == 6'b110111);
  assign pair_cp = {({1'b0, off_r} + 11'h040), unit[9:0]};

  // lone low surrogate in a first unit encodes as the replacement character
  always_comb begin
    if (mode_r == jsu_pkg::MODE_HEX2 && unit_lo) begin
      cp_sel = pair_cp;
    end else if (unit_lo) begin
      cp_sel = 21'h00FFFD;
    end else begin
      cp_sel = {5'd0, unit};
    end
  end

  assign enc = utf8_enc(cp_sel);

  always_comb begin
    esc_ok  = 1'b1;
    esc_val = 8'h00;
    case (b)
      jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH: esc_val = b;
      jsu_pkg::CH_B: esc_val = 8'h08;
      jsu_pkg::CH_F: esc_val = 8'h0C;
      jsu_pkg::CH_N: esc_val = 8'h0A;
      jsu_pkg::CH_R: esc_val = 8'h0D;
      jsu_pkg::CH_T: esc_val = 8'h09;
      default: esc_ok = 1'b0;
    endcase
  end

  // plain byte and escape letter results, shared by several modes
  always_comb begin
    plain_pay  = '0;
    plain_term = jsu_pkg::ST_DATA;
    if (b == jsu_pkg::CH_QUOTE) begin
      plain_term = jsu_pkg::ST_DONE;
    end else if (b < jsu_pkg::CTRL_LIMIT) begin
      plain_term = jsu_pkg::ST_CTRL;
    end else if (b != jsu_pkg::CH_BSLASH) begin
      plain_pay.n        = 3'd1;
      plain_pay.bytes[0] = b;
    end
    esc_pay  = '0;
    esc_term = jsu_pkg::ST_DATA;
    if (esc_ok) begin
      esc_pay.n        = 3'd1;
      esc_pay.bytes[0] = esc_val;
    end else if (b != jsu_pkg::CH_U) begin
      esc_term = jsu_pkg::ST_BAD_ESC;
    end
  end

  // results of this item
  always_comb begin
    rep  = 1'b0;
    pay  = '0;
    term = jsu_pkg::ST_DATA;
    if (endm) begin
      rep = (mode_r == jsu_pkg::MODE_WAIT_BS) || (mode_r == jsu_pkg::MODE_WAIT_U);
      if (mode_r == jsu_pkg::MODE_HEX1 || mode_r == jsu_pkg::MODE_HEX2) begin
        term = jsu_pkg::ST_BAD_HEX;
      end else begin
        term = jsu_pkg::ST_UNTERM;
      end
    end else begin
      case (mode_r)
        jsu_pkg::MODE_ESC: begin
          pay  = esc_pay;
          term = esc_term;
        end
        jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2: begin
          if (!hex_ok) begin
            term = jsu_pkg::ST_BAD_HEX;
          end else if (hcnt_r == 2'd3) begin
            if (mode_r == jsu_pkg::MODE_HEX2 && !unit_lo) begin
              rep = 1'b1;
            end
            if (!unit_hi) begin
              pay = enc;
            end
          end
        end
        jsu_pkg::MODE_WAIT_BS: begin
          if (b != jsu_pkg::CH_BSLASH) begin
            rep  = 1'b1;
            pay  = plain_pay;
            term = plain_term;
          end
        end
        jsu_pkg::MODE_WAIT_U: begin
          if (b != jsu_pkg::CH_U) begin
            rep  = 1'b1;
            pay  = esc_pay;
            term = esc_term;
          end
        end
        default: begin
          pay  = plain_pay;
          term = plain_term;
        end
      endcase
    end
  end

  always_comb begin
    burst.status = term;
    burst.cnt    = {1'b0, rep, rep} + pay.n
                   + {2'b00, (term != jsu_pkg::ST_DATA)};
    if (rep) begin
      burst.bytes = {pay.bytes[2], pay.bytes[1], pay.bytes[0],
                     jsu_pkg::REPL_B2, jsu_pkg::REPL_B1, jsu_pkg::REPL_B0};
    end else begin
      burst.bytes = {16'h0000, pay.bytes};
    end
  end

  assign push = fire && (burst.cnt != 3'd0);

  // next state
  always_comb begin
    mode_nxt = mode_r;
    hcnt_nxt = hcnt_r;
    acc_nxt  = acc_r;
    off_nxt  = off_r;
    if (endm) begin
      mode_nxt = jsu_pkg::MODE_PLAIN;
    end else begin
      case (mode_r)
        jsu_pkg::MODE_ESC: begin
          mode_nxt = (b == jsu_pkg::CH_U) ? jsu_pkg::MODE_HEX1 : jsu_pkg::MODE_PLAIN;
          hcnt_nxt = 2'd0;
          acc_nxt  = 16'h0000;
        end
        jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2: begin
          if (hcnt_r != 2'd3) begin
            hcnt_nxt = hcnt_r + 2'd1;
            acc_nxt  = unit;
          end else begin
            hcnt_nxt = 2'd0;
            acc_nxt  = 16'h0000;
            if (unit_hi) begin
              mode_nxt = jsu_pkg::MODE_WAIT_BS;
              off_nxt  = unit[9:0];
            end else begin
              mode_nxt = jsu_pkg::MODE_PLAIN;
            end
          end
        end
        jsu_pkg::MODE_WAIT_BS: begin
          mode_nxt = (b == jsu_pkg::CH_BSLASH) ? jsu_pkg::MODE_WAIT_U
                                               : jsu_pkg::MODE_PLAIN;
        end
        jsu_pkg::MODE_WAIT_U: begin
          mode_nxt = (b == jsu_pkg::CH_U) ? jsu_pkg::MODE_HEX2 : jsu_pkg::MODE_PLAIN;
          hcnt_nxt = 2'd0;
          acc_nxt  = 16'h0000;
        end
        default: begin
          mode_nxt = (b == jsu_pkg::CH_BSLASH) ? jsu_pkg::MODE_ESC : jsu_pkg::MODE_PLAIN;
        end
      endcase
    end
    // a terminating result returns everything to the start of a string
    if (term != jsu_pkg::ST_DATA) begin
      mode_nxt = jsu_pkg::MODE_PLAIN;
      hcnt_nxt = 2'd0;
      acc_nxt  = 16'h0000;
      off_nxt  = 10'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= jsu_pkg::MODE_PLAIN;
      hcnt_r <= 2'd0;
      acc_r  <= 16'h0000;
      off_r  <= 10'd0;
    end else if (fire) begin
      mode_r <= mode_nxt;
      hcnt_r <= hcnt_nxt;
      acc_r  <= acc_nxt;
      off_r  <= off_nxt;
    end
  end

endmodule

`default_nettype wire

@@ design/jsu_fifo.sv @@
// short burst queue between the decoder and the output serializer
`default_nettype none

module jsu_fifo #(
  parameter int DEPTH = 4
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  push,
  input  jsu_pkg::jsu_burst_t  wr_data,
  output logic                 full,
  input  wire                  pop,
  output logic                 q_valid,
  output jsu_pkg::jsu_burst_t  q_head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  jsu_pkg::jsu_burst_t mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == CW'(DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_head  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("queue count exceeds depth");
`endif

endmodule

`default_nettype wire

@@ design/jsu_back.sv @@
// back end: walks each queued burst and drives one result item per cycle while out_tready allows
`default_nettype none

module jsu_back (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  q_valid,
  input  jsu_pkg::jsu_burst_t  q_head,
  output logic                 q_pop,
  output logic                 out_tvalid,
  input  wire                  out_tready,
  output logic [7:0]           out_tdata,  // [7:0] out_byte
  output logic [2:0]           out_tuser,  // [2:0] status
  output logic                 out_tlast   // last_of_run
);

  logic        out_valid_r;
  logic [2:0]  idx_r, idx_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic [2:0]  status_r, status_nxt;
  logic        last_r;
  logic        load, last;

  assign load  = q_valid && (!out_valid_r || out_tready);
  assign last  = (idx_r == q_head.cnt - 3'd1);
  assign q_pop = load && last;

  always_comb begin
    idx_nxt = last ? 3'd0 : idx_r + 3'd1;
    if (last && q_head.status != jsu_pkg::ST_DATA) begin
      byte_nxt   = 8'h00;
      status_nxt = q_head.status;
    end else begin
      byte_nxt   = q_head.bytes[idx_r];
      status_nxt = jsu_pkg::ST_DATA;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 3'd0;
    end else if (load) begin
      out_valid_r <= 1'b1;
      idx_r       <= idx_nxt;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r   <= byte_nxt;
      status_r <= status_nxt;
      last_r   <= last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = byte_r;
  assign out_tuser  = status_r;
  assign out_tlast  = last_r;

`ifndef NO_ASSERTIONS
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !last_r) |-> (status_r == jsu_pkg::ST_DATA))
    else $error("terminating status before the end of a burst");
  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r != jsu_pkg::ST_DATA) |-> (byte_r == 8'h00))
    else $error("status item carries a data byte");
  a_burst_len: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid |-> (q_head.cnt != 3'd0 && q_head.cnt <= 3'(jsu_pkg::MAX_RESULTS)))
    else $error("queued burst has an illegal length");
`endif

endmodule

`default_nettype wire
